>>> hdl/double_ended_queue_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue.
// Each macro expands to one labelled concurrent assertion on clk, held off
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define DQE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define DQE_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dqe_pkg.sv
// ---------------------------------------------------------------------------
// Double-ended queue package
// Transaction types, opcodes and chain control shared by all queue modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dqe_pkg;

  // Field widths fixed by the transaction format.
  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int COUNT_OUT_W = 11;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

  // Input transaction.
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [WORD_W-1:0] push_value;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [WORD_W-1:0]      popped_word;
    logic                   popped_valid;
    logic [WORD_W-1:0]      front_word;
    logic [WORD_W-1:0]      back_word;
    logic                   ends_valid;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
    logic                   push_dropped;
  } out_item_t;

  // Per-chain control: shift towards the far end (insert at cell 0), shift
  // towards cell 0 (remove cell 0), or write the new word at the fill level.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic append;
  } chain_ctrl_t;

endpackage

>>> hdl/double_ended_queue.sv
// ---------------------------------------------------------------------------
// Double-ended queue
// Output: the result transaction is registered and appears in the cycle after its input is taken.
// Throughput: one transaction per cycle while the output is not stalled; every cell of both chains updates
// in the same cycle, so nothing is iterated.
// Reset: fill count and output valid clear; the cells hold no reset and are
// only read within the fill count, so no clearing pass is needed.
// Two mirrored cell chains hold the contents: one with the front at cell 0,
// one with the back at cell 0, so both ends are read at fixed places.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dqe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dqe_pkg::out_item_t  out_data
);

  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CountOutW = dqe_pkg::COUNT_OUT_W;

  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  dqe_pkg::out_item_t         out_data_r;
  dqe_pkg::out_item_t         out_data_nxt;

  logic                       accept;
  logic                       is_full;
  logic                       is_empty_now;
  logic                       do_push_front;
  logic                       do_push_back;
  logic                       do_pop_front;
  logic                       do_pop_back;
  logic                       push_refused;
  logic [dqe_pkg::WORD_W-1:0] front0;
  logic [dqe_pkg::WORD_W-1:0] front1;
  logic [dqe_pkg::WORD_W-1:0] back0;
  logic [dqe_pkg::WORD_W-1:0] back1;
  logic [dqe_pkg::WORD_W-1:0] front_after;
  logic [dqe_pkg::WORD_W-1:0] back_after;
  logic [dqe_pkg::WORD_W-1:0] popped;
  dqe_pkg::chain_ctrl_t       front_ctrl;
  dqe_pkg::chain_ctrl_t       back_ctrl;

  // A transaction is taken whenever the output register is free or draining.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full      = (count_r == CNT_W'(DEPTH));
  assign is_empty_now = (count_r == '0);

  // Decode the operation against the current fill level.
  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    do_pop_back   = 1'b0;
    push_refused  = 1'b0;
    case (in_data.opcode)
      dqe_pkg::OP_PUSH_FRONT: begin
        do_push_front = accept && !is_full;
        push_refused  = is_full;
      end
      dqe_pkg::OP_PUSH_BACK: begin
        do_push_back = accept && !is_full;
        push_refused = is_full;
      end
      dqe_pkg::OP_POP_FRONT: begin
        do_pop_front = accept && !is_empty_now;
      end
      dqe_pkg::OP_POP_BACK: begin
        do_pop_back = accept && !is_empty_now;
      end
      default: begin
      end
    endcase
  end

  // Chain controls: a push at one end shifts that end's chain and appends
  // to the mirrored chain; a pop shifts its own chain only.
  always_comb begin
    front_ctrl.shift_up   = do_push_front;
    front_ctrl.shift_down = do_pop_front;
    front_ctrl.append     = do_push_back;
    back_ctrl.shift_up    = do_push_back;
    back_ctrl.shift_down  = do_pop_back;
    back_ctrl.append      = do_push_front;
  end

  dqe_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_chain (
    .clk        (clk),
    .ctrl       (front_ctrl),
    .fill_count (count_r),
    .push_word  (in_data.push_value),
    .end_word   (front0),
    .next_word  (front1)
  );

  dqe_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_back_chain (
    .clk        (clk),
    .ctrl       (back_ctrl),
    .fill_count (count_r),
    .push_word  (in_data.push_value),
    .end_word   (back0),
    .next_word  (back1)
  );

  // Next fill count.
  always_comb begin
    if (do_push_front || do_push_back) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop_front || do_pop_back) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // End words as they stand after the operation.
  always_comb begin
    front_after = front0;
    back_after  = back0;
    popped      = '0;
    if (do_push_front) begin
      front_after = in_data.push_value;
      if (is_empty_now) begin
        back_after = in_data.push_value;
      end
    end else if (do_push_back) begin
      back_after = in_data.push_value;
      if (is_empty_now) begin
        front_after = in_data.push_value;
      end
    end else if (do_pop_front) begin
      popped      = front0;
      front_after = front1;
    end else if (do_pop_back) begin
      popped     = back0;
      back_after = back1;
    end
  end

  // Assemble the result transaction.
  always_comb begin
    out_data_nxt.popped_word  = popped;
    out_data_nxt.popped_valid = do_pop_front || do_pop_back;
    out_data_nxt.ends_valid   = (count_nxt != '0);
    out_data_nxt.front_word   = (count_nxt != '0) ? front_after : '0;
    out_data_nxt.back_word    = (count_nxt != '0) ? back_after : '0;
    out_data_nxt.entry_count  = CountOutW'(count_nxt);
    out_data_nxt.is_empty     = (count_nxt == '0);
    out_data_nxt.push_dropped = push_refused;
  end

  // Output register valid: set on a new transaction, held while stalled.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Assertions.
  `include "double_ended_queue_assert.svh"

  `DQE_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "Fill count exceeds depth.")
  `DQE_ASSERT_ALWAYS(a_single_ends, (count_r != CNT_W'(1)) || (front0 == back0), "Chains disagree on the only entry.")
  `DQE_ASSERT_NEXT(a_push_grows, do_push_front || do_push_back, count_r == $past(count_r) + CNT_W'(1), "Push did not grow the queue.")
  `DQE_ASSERT_NEXT(a_pop_reports, do_pop_front || do_pop_back, out_valid_r && out_data_r.popped_valid, "Pop not reported as valid.")

endmodule

>>> hdl/dqe_cell.sv
// ---------------------------------------------------------------------------
// Queue storage cell
// Holds one word and takes a neighbour's word, the pushed word or its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dqe_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 11
) (
  input  logic                       clk,
  input  dqe_pkg::chain_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]           fill_count,
  input  logic [dqe_pkg::WORD_W-1:0] push_word,
  input  logic [dqe_pkg::WORD_W-1:0] lower_word,
  input  logic [dqe_pkg::WORD_W-1:0] upper_word,
  output logic [dqe_pkg::WORD_W-1:0] word
);

  logic [dqe_pkg::WORD_W-1:0] word_r;
  logic [dqe_pkg::WORD_W-1:0] word_nxt;
  logic                       at_level;

  // This cell is the first free place of the chain.
  assign at_level = (fill_count == CNT_W'(CELL_IDX));

  // Select the next content of the cell.
  always_comb begin
    if (ctrl.shift_up) begin
      word_nxt = lower_word;
    end else if (ctrl.shift_down) begin
      word_nxt = upper_word;
    end else if (ctrl.append && at_level) begin
      word_nxt = push_word;
    end else begin
      word_nxt = word_r;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

>>> hdl/dqe_chain.sv
// ---------------------------------------------------------------------------
// Queue cell chain
// A row of cells with one end fixed at cell 0; exposes the first two words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dqe_chain #(
  parameter int DEPTH = 1024,
  parameter int CNT_W = 11
) (
  input  logic                       clk,
  input  dqe_pkg::chain_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]           fill_count,
  input  logic [dqe_pkg::WORD_W-1:0] push_word,
  output logic [dqe_pkg::WORD_W-1:0] end_word,
  output logic [dqe_pkg::WORD_W-1:0] next_word
);

  logic [dqe_pkg::WORD_W-1:0] words [DEPTH];

  // Each cell sees its two neighbours; cell 0 takes the pushed word from
  // below and the last cell keeps its own word from above.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dqe_pkg::WORD_W-1:0] lower_w;
    logic [dqe_pkg::WORD_W-1:0] upper_w;

    if (i == 0) begin : g_first
      assign lower_w = push_word;
    end else begin : g_mid_low
      assign lower_w = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_w = words[i];
    end else begin : g_mid_high
      assign upper_w = words[i+1];
    end

    dqe_cell #(
      .CELL_IDX (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .fill_count (fill_count),
      .push_word  (push_word),
      .lower_word (lower_w),
      .upper_word (upper_w),
      .word       (words[i])
    );
  end

  assign end_word  = words[0];
  assign next_word = words[1];

endmodule
